// File: hdl/sexpr_stream_parser_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the s-expression stream parser
// Concurrent checks clocked on clk, off while rst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SEXPR_STREAM_PARSER_MACROS_SVH
`define SEXPR_STREAM_PARSER_MACROS_SVH

`ifndef SYNTHESIS

`define SXP_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("sxp assertion failed");

`define SXP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sxp assertion failed");

`define SXP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sxp assertion failed");

`else

`define SXP_ASSERT(lbl, expr)
`define SXP_ASSERT_IMP(lbl, ante, cons)
`define SXP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hdl/sxp_pkg.sv
// ----------------------------------------------------------------------------
// sxp_pkg
// Shared constants, codes and record types of the s-expression stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sxp_pkg;

    localparam int MAX_DEPTH  = 32;
    localparam int DEPTH_W    = $clog2(MAX_DEPTH + 1);
    localparam int STACK_AW   = $clog2(MAX_DEPTH);
    localparam int STACK_W    = 32;

    localparam logic [15:0] ITEM_LIMIT   = 16'd65535;
    localparam logic [15:0] NONE_ID      = 16'hFFFF;
    localparam logic [15:0] OFFSET_LIMIT = 16'd65534;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_LIST  = 2'd0,
        KIND_ATOM  = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ERR_NONE          = 4'd0,
        ERR_TOO_DEEP      = 4'd1,
        ERR_SECOND_TOP    = 4'd2,
        ERR_TOO_MANY      = 4'd3,
        ERR_STRAY_CLOSE   = 4'd4,
        ERR_TOP_ATOM      = 4'd5,
        ERR_MISSING_QUOTE = 4'd6,
        ERR_STRAY_QUOTE   = 4'd7,
        ERR_MISSING_CLOSE = 4'd8,
        ERR_TOO_LONG      = 4'd9
    } err_t;

    typedef enum logic [1:0] {
        MODE_BETWEEN  = 2'd0,
        MODE_BARE     = 2'd1,
        MODE_QUOTED   = 2'd2,
        MODE_FINISHED = 2'd3
    } mode_t;

    typedef struct packed {
        logic [15:0] item;
        logic [15:0] last;
    } stack_entry_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] item;
        logic [15:0] parent;
        logic [15:0] prev;
        logic [15:0] span_start;
        logic [15:0] span_end;
        err_t        error_code;
        logic [15:0] error_offset;
        logic        last;
    } record_t;

    // up to two records per input word, first goes out first
    typedef struct packed {
        logic [1:0] num;
        record_t    first;
        record_t    second;
    } rec_push_t;

endpackage

`default_nettype wire

// File: hdl/sxp_ram.sv
// ----------------------------------------------------------------------------
// sxp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sxp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

// File: hdl/sxp_core.sv
// ----------------------------------------------------------------------------
// sxp_core
// Lexer and list stack: one input word per step, up to two records out.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sexpr_stream_parser_macros.svh"

module sxp_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic              step_action,
    input  wire logic [7:0]        step_byte,
    output sxp_pkg::rec_push_t     push
);

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;

    localparam int DW = sxp_pkg::DEPTH_W;
    localparam int AW = sxp_pkg::STACK_AW;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    sxp_pkg::mode_t         mode_reg, mode_next;
    logic [DW-1:0]          depth_reg, depth_next;
    logic [15:0]            top_item_reg, top_item_next;
    logic [15:0]            top_last_reg, top_last_next;
    logic [15:0]            item_count_reg, item_count_next;
    logic [15:0]            offset_reg, offset_next;
    logic [15:0]            atom_item_reg, atom_item_next;
    logic [15:0]            atom_begin_reg, atom_begin_next;
    logic                   byp_sel_reg, byp_sel_next;
    sxp_pkg::stack_entry_t  byp_reg, byp_next;

    sxp_pkg::stack_entry_t  ram_rdata;
    sxp_pkg::stack_entry_t  second;
    sxp_pkg::stack_entry_t  wr_entry;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;

    logic                   close_atom;
    logic                   open_list;
    logic                   pop_list;
    logic                   start_atom;
    logic                   start_quoted;
    logic                   advance;
    logic                   finish_ok;
    logic                   scan;
    sxp_pkg::err_t          err_code;
    logic                   is_err;
    logic                   at_root;
    logic                   at_max;
    logic                   items_full;
    logic [15:0]            last_after;

    sxp_pkg::record_t       rec_atom;
    sxp_pkg::record_t       rec_tail;
    logic                   tail_valid;

    assign at_root    = (depth_reg == DW'(1));
    assign at_max     = (depth_reg >= DW'(sxp_pkg::MAX_DEPTH));
    assign items_full = (item_count_reg >= sxp_pkg::ITEM_LIMIT);
    assign last_after = close_atom ? atom_item_reg : top_last_reg;
    assign is_err     = (err_code != sxp_pkg::ERR_NONE);
    assign second     = byp_sel_reg ? byp_reg : ram_rdata;

    // decode of one word
    always_comb
    begin
        close_atom   = 1'b0;
        open_list    = 1'b0;
        pop_list     = 1'b0;
        start_atom   = 1'b0;
        start_quoted = 1'b0;
        advance      = 1'b0;
        finish_ok    = 1'b0;
        scan         = 1'b0;
        err_code     = sxp_pkg::ERR_NONE;
        if (step && (mode_reg != sxp_pkg::MODE_FINISHED))
        begin
            if (step_action)
            begin
                if (mode_reg == sxp_pkg::MODE_QUOTED)
                begin
                    err_code = sxp_pkg::ERR_MISSING_QUOTE;
                end
                else
                begin
                    close_atom = (mode_reg == sxp_pkg::MODE_BARE);
                    if (!at_root)
                    begin
                        err_code = sxp_pkg::ERR_MISSING_CLOSE;
                    end
                    else
                    begin
                        finish_ok = 1'b1;
                    end
                end
            end
            else if (offset_reg >= sxp_pkg::OFFSET_LIMIT)
            begin
                err_code = sxp_pkg::ERR_TOO_LONG;
            end
            else
            begin
                advance = 1'b1;
                unique case (mode_reg)
                    sxp_pkg::MODE_QUOTED:
                    begin
                        close_atom = (step_byte == CH_QUOTE);
                    end
                    sxp_pkg::MODE_BARE:
                    begin
                        if (step_byte == CH_QUOTE)
                        begin
                            err_code = sxp_pkg::ERR_STRAY_QUOTE;
                        end
                        else if (is_space(step_byte))
                        begin
                            close_atom = 1'b1;
                        end
                        else if ((step_byte == CH_LPAREN) || (step_byte == CH_RPAREN))
                        begin
                            close_atom = 1'b1;
                            scan       = 1'b1;
                        end
                    end
                    sxp_pkg::MODE_BETWEEN:
                    begin
                        scan = 1'b1;
                    end
                    sxp_pkg::MODE_FINISHED:
                    begin
                        scan = 1'b0;
                    end
                endcase

                if (scan && !is_space(step_byte))
                begin
                    if (step_byte == CH_LPAREN)
                    begin
                        if (at_max)
                        begin
                            err_code = sxp_pkg::ERR_TOO_DEEP;
                        end
                        else if (at_root && (last_after != sxp_pkg::NONE_ID))
                        begin
                            err_code = sxp_pkg::ERR_SECOND_TOP;
                        end
                        else if (items_full)
                        begin
                            err_code = sxp_pkg::ERR_TOO_MANY;
                        end
                        else
                        begin
                            open_list = 1'b1;
                        end
                    end
                    else if (step_byte == CH_RPAREN)
                    begin
                        if (at_root)
                        begin
                            err_code = sxp_pkg::ERR_STRAY_CLOSE;
                        end
                        else
                        begin
                            pop_list = 1'b1;
                        end
                    end
                    else if (at_root)
                    begin
                        err_code = sxp_pkg::ERR_TOP_ATOM;
                    end
                    else if (items_full)
                    begin
                        err_code = sxp_pkg::ERR_TOO_MANY;
                    end
                    else
                    begin
                        start_atom   = 1'b1;
                        start_quoted = (step_byte == CH_QUOTE);
                    end
                end
            end
        end
    end

    // next state
    always_comb
    begin
        mode_next       = mode_reg;
        depth_next      = depth_reg;
        top_item_next   = top_item_reg;
        top_last_next   = top_last_reg;
        item_count_next = item_count_reg;
        offset_next     = offset_reg;
        atom_item_next  = atom_item_reg;
        atom_begin_next = atom_begin_reg;

        if (is_err || finish_ok)
        begin
            mode_next = sxp_pkg::MODE_FINISHED;
        end
        else if (start_atom)
        begin
            mode_next = start_quoted ? sxp_pkg::MODE_QUOTED : sxp_pkg::MODE_BARE;
        end
        else if (close_atom)
        begin
            mode_next = sxp_pkg::MODE_BETWEEN;
        end

        if (open_list)
        begin
            depth_next    = depth_reg + DW'(1);
            top_item_next = item_count_reg;
            top_last_next = sxp_pkg::NONE_ID;
        end
        else if (pop_list)
        begin
            depth_next    = depth_reg - DW'(1);
            top_item_next = second.item;
            top_last_next = second.last;
        end
        else if (close_atom)
        begin
            top_last_next = atom_item_reg;
        end

        if (open_list || start_atom)
        begin
            item_count_next = item_count_reg + 16'd1;
        end

        if (start_atom)
        begin
            atom_item_next  = item_count_reg;
            atom_begin_next = start_quoted ? (offset_reg + 16'd1) : offset_reg;
        end

        if (advance)
        begin
            offset_next = offset_reg + 16'd1;
        end
    end

    // stack memory holds every open entry below the top
    assign wr_entry.item = top_item_reg;
    assign wr_entry.last = item_count_reg;
    assign wr_addr       = AW'(depth_reg - DW'(1));
    assign rd_addr       = AW'(depth_next - DW'(2));
    assign byp_sel_next  = open_list;
    assign byp_next      = wr_entry;

    sxp_ram #(
        .WIDTH (sxp_pkg::STACK_W),
        .DEPTH (sxp_pkg::MAX_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (open_list),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // records
    always_comb
    begin
        rec_atom            = '0;
        rec_atom.kind       = sxp_pkg::KIND_ATOM;
        rec_atom.item       = atom_item_reg;
        rec_atom.parent     = top_item_reg;
        rec_atom.prev       = top_last_reg;
        rec_atom.span_start = atom_begin_reg;
        rec_atom.span_end   = offset_reg;
        rec_atom.error_code = sxp_pkg::ERR_NONE;

        rec_tail            = '0;
        rec_tail.prev       = sxp_pkg::NONE_ID;
        rec_tail.error_code = sxp_pkg::ERR_NONE;
        rec_tail.last       = 1'b1;
        if (is_err)
        begin
            rec_tail.kind         = sxp_pkg::KIND_ERROR;
            rec_tail.error_code   = err_code;
            rec_tail.error_offset = offset_reg;
        end
        else if (finish_ok)
        begin
            rec_tail.kind = sxp_pkg::KIND_DONE;
        end
        else
        begin
            rec_tail.kind       = sxp_pkg::KIND_LIST;
            rec_tail.item       = item_count_reg;
            rec_tail.parent     = top_item_reg;
            rec_tail.prev       = last_after;
            rec_tail.span_start = offset_reg;
        end

        tail_valid    = is_err || finish_ok || open_list;
        rec_atom.last = !tail_valid;

        push.num    = {1'b0, close_atom} + {1'b0, tail_valid};
        push.first  = close_atom ? rec_atom : rec_tail;
        push.second = rec_tail;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= sxp_pkg::MODE_BETWEEN;
            depth_reg      <= DW'(1);
            top_item_reg   <= 16'd0;
            top_last_reg   <= sxp_pkg::NONE_ID;
            item_count_reg <= 16'd1;
            offset_reg     <= 16'd0;
            atom_item_reg  <= 16'd0;
            atom_begin_reg <= 16'd0;
            byp_sel_reg    <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            depth_reg      <= depth_next;
            top_item_reg   <= top_item_next;
            top_last_reg   <= top_last_next;
            item_count_reg <= item_count_next;
            offset_reg     <= offset_next;
            atom_item_reg  <= atom_item_next;
            atom_begin_reg <= atom_begin_next;
            byp_sel_reg    <= byp_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_reg <= byp_next;
    end

    `SXP_ASSERT(core_depth_range, (depth_reg != '0) && (depth_reg <= DW'(sxp_pkg::MAX_DEPTH)))
    `SXP_ASSERT(core_count_ahead, item_count_reg > top_item_reg)
    `SXP_ASSERT_NEXT(core_finished_sticks, mode_reg == sxp_pkg::MODE_FINISHED, mode_reg == sxp_pkg::MODE_FINISHED)
    `SXP_ASSERT_NEXT(core_push_bypass, open_list, byp_sel_reg && (depth_reg == $past(depth_reg) + DW'(1)))

endmodule

`default_nettype wire

// File: hdl/sxp_out_fifo.sv
// ----------------------------------------------------------------------------
// sxp_out_fifo
// Small record queue: takes up to two records a cycle, hands out one when head_take is high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sexpr_stream_parser_macros.svh"

module sxp_out_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sxp_pkg::rec_push_t push,
    output logic                    space_ok,
    output logic                    head_valid,
    input  wire logic               head_take,
    output sxp_pkg::record_t        head
);

    localparam int AW = sxp_pkg::FIFO_AW;
    localparam int CW = sxp_pkg::FIFO_CW;

    sxp_pkg::record_t  fifo_reg [sxp_pkg::FIFO_DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              pop;
    logic [AW-1:0]     wr_ptr_plus1;

    assign head_valid   = (count_reg != '0);
    assign head         = fifo_reg[rd_ptr_reg];
    assign space_ok     = (count_reg <= CW'(sxp_pkg::FIFO_DEPTH - 2));
    assign pop          = head_valid && head_take;
    assign wr_ptr_plus1 = wr_ptr_reg + AW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push.num);
        rd_ptr_next = pop ? (rd_ptr_reg + AW'(1)) : rd_ptr_reg;
        count_next  = count_reg + CW'(push.num) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2)
        begin
            fifo_reg[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `SXP_ASSERT(fifo_count_bound, count_reg <= CW'(sxp_pkg::FIFO_DEPTH))
    `SXP_ASSERT_IMP(fifo_no_overflow, push.num != 2'd0, count_reg <= CW'(sxp_pkg::FIFO_DEPTH - 2))
    `SXP_ASSERT(fifo_ptr_track, wr_ptr_reg == AW'(rd_ptr_reg + AW'(count_reg)))

endmodule

`default_nettype wire

// File: hdl/sexpr_stream_parser.sv
// ----------------------------------------------------------------------------
// sexpr_stream_parser
// A taken word is held in an input register until it steps the core; its
// records go into the record queue, whose head is offered on out_valid.
// Throughput: one word per cycle; a word can make two records (atom plus list,
// error or done), and the input stalls while the queue holds three or more.
// Reset: asynchronous, active low; parser returns to the root list at offset 0.
// ----------------------------------------------------------------------------
`default_nettype none

module sexpr_stream_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        action,
    input  wire logic [7:0]  text_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       record_kind,
    output logic [15:0]      item_index,
    output logic [15:0]      parent_item,
    output logic [15:0]      prev_sibling,
    output logic [15:0]      span_start,
    output logic [15:0]      span_end,
    output logic [3:0]       error_code,
    output logic [15:0]      error_offset,
    output logic             last_result
);

    logic               in_valid_reg, in_valid_next;
    logic               in_action_reg;
    logic [7:0]         in_byte_reg;
    logic               space_ok;
    logic               step;
    logic               accept;
    sxp_pkg::rec_push_t push;
    sxp_pkg::record_t   head;

    assign step     = in_valid_reg && space_ok;
    assign in_stall = in_valid_reg && !space_ok;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_action_reg <= action;
            in_byte_reg   <= text_byte;
        end
    end

    sxp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .step_action (in_action_reg),
        .step_byte   (in_byte_reg),
        .push        (push)
    );

    sxp_out_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space_ok   (space_ok),
        .head_valid (out_valid),
        .head_take  (!out_stall),
        .head       (head)
    );

    assign record_kind  = head.kind;
    assign item_index   = head.item;
    assign parent_item  = head.parent;
    assign prev_sibling = head.prev;
    assign span_start   = head.span_start;
    assign span_end     = head.span_end;
    assign error_code   = head.error_code;
    assign error_offset = head.error_offset;
    assign last_result  = head.last;

endmodule

`default_nettype wire
